// ----- rtl/rotate_point_3d_xyz_defines.svh -----
// Assertion macros used by the rotator top level.
`ifndef ROTATE_POINT_3D_XYZ_DEFINES_SVH
`define ROTATE_POINT_3D_XYZ_DEFINES_SVH

// Checked property, masked while in reset.
`define RP3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property, also active during reset.
`define RP3_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/rp3_pkg.sv -----
// Types, constants and helpers for the 3D point rotator.
`timescale 1ns / 1ps
package rp3_pkg;

  localparam int COORD_W = 24;
  localparam int TRIG_F  = 15;
  localparam int TRIG_W  = TRIG_F + 2;
  localparam int PROD_W  = COORD_W + TRIG_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int SH_W    = SUM_W - TRIG_F;
  localparam int ANGLE_W = 12;

  // register indexes of the configuration port
  localparam logic [1:0] REG_ANGLE_X = 2'd0;
  localparam logic [1:0] REG_ANGLE_Y = 2'd1;
  localparam logic [1:0] REG_ANGLE_Z = 2'd2;

  // trig pipeline depth, angle register to sine/cosine register
  localparam int TRIG_LAT = 13;

  localparam logic [ANGLE_W-1:0] FULL_TURN  = 12'd3600;
  localparam logic [ANGLE_W-1:0] TURN_3Q    = 12'd2700;
  localparam logic [ANGLE_W-1:0] HALF_TURN  = 12'd1800;
  localparam logic [ANGLE_W-1:0] QUARTER    = 12'd900;
  localparam logic [ANGLE_W-1:0] EIGHTH     = 12'd450;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // pi/1800 in Q30
  localparam logic [20:0] RAD_Q30 = 21'd1874033;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [30:0] TRIG_RND = 31'(1) << (29 - TRIG_F);

  // exact reciprocal division: floor(v/d) = (v*M) >> K for v < 2^31
  // sine terms divide by 72, 42, 20, 6; cosine by 56, 30, 12, 2
  localparam logic [31:0] SIN_RECIP [4] = '{32'd3817748708, 32'd3272356036,
                                             32'd3435973837, 32'd2863311531};
  localparam int          SIN_SHIFT [4] = '{38, 37, 36, 34};
  localparam logic [31:0] COS_RECIP [4] = '{32'd2454267027, 32'd2290649225,
                                             32'd2863311531, 32'd2147483648};
  localparam int          COS_SHIFT [4] = '{37, 36, 35, 32};

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [TRIG_W-1:0]  trig_val_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [SH_W-1:0]    sh_t;

  typedef struct packed {
    trig_val_t sin_v;
    trig_val_t cos_v;
  } trig_t;

  typedef struct packed {
    logic   sat;
    coord_t val;
  } rc_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam sum_t   RND_HALF  = sum_t'(1) <<< (TRIG_F - 1);

  // round to nearest (ties up) by 2^TRIG_F, then clip to the coordinate range
  function automatic rc_t rnd_clip(sum_t v);
    sum_t h;
    sh_t  sh;
    rc_t  r;
    h  = v + RND_HALF;
    sh = h[SUM_W-1:TRIG_F];
    r.sat = 1'b0;
    r.val = sh[COORD_W-1:0];
    if (sh > sh_t'(COORD_MAX)) begin
      r.sat = 1'b1;
      r.val = COORD_MAX;
    end else if (sh < sh_t'(COORD_MIN)) begin
      r.sat = 1'b1;
      r.val = COORD_MIN;
    end
    return r;
  endfunction

  function automatic prod_t mul_ct(coord_t a, trig_val_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

endpackage

// ----- rtl/rp3_trig.sv -----
// Pipelined sine/cosine of one angle register (Taylor series in Q30).
`timescale 1ns / 1ps
module rp3_trig
  import rp3_pkg::*;
(
  input  logic               clk,
  input  logic [ANGLE_W-1:0] angle,
  output trig_t              trig
);

  // Free running. The user must keep the angle steady while transactions are
  // in flight; the block does not enforce it. Stages read earlier operands directly, no path exceeds TRIG_LAT regs.

  logic [ANGLE_W-1:0] a_w;
  logic [ANGLE_W-1:0] base;
  logic [1:0]         q_c;
  logic [9:0]         r_c;

  logic [8:0]  t0_r;
  logic [1:0]  q0_r;
  logic        sw0_r;
  logic [29:0] x1_r;
  logic [29:0] x2_r;
  logic [29:0] ps_r [4];
  logic [29:0] pc_r [4];
  logic [30:0] s_r  [1:4];
  logic [30:0] c_r  [1:4];
  logic [30:0] sf_r;
  logic [30:0] cf_r;
  trig_t       trig_r;

  always_comb begin
    a_w = (angle >= FULL_TURN) ? angle - FULL_TURN : angle;
    if (a_w >= TURN_3Q) begin
      q_c = QUAD_3; base = TURN_3Q;
    end else if (a_w >= HALF_TURN) begin
      q_c = QUAD_2; base = HALF_TURN;
    end else if (a_w >= QUARTER) begin
      q_c = QUAD_1; base = QUARTER;
    end else begin
      q_c = QUAD_0; base = '0;
    end
    r_c = 10'(a_w - base);
  end

  always_ff @(posedge clk) begin
    q0_r  <= q_c;
    sw0_r <= (12'(r_c) > EIGHTH);
    t0_r  <= (12'(r_c) > EIGHTH) ? 9'(QUARTER - 12'(r_c)) : r_c[8:0];
  end

  logic [59:0] xsq;
  always_comb xsq = 60'(x1_r) * 60'(x1_r);

  always_ff @(posedge clk) begin
    x1_r <= 30'(30'(t0_r) * 30'(RAD_Q30));
    x2_r <= xsq[59:30];
  end

  // Horner steps: multiply (copy at h=0), then reciprocal divide, subtract
  for (genvar h = 0; h < 4; h++) begin : g_horner
    logic [61:0] dvs;
    logic [61:0] dvc;
    if (h == 0) begin : g_first
      always_ff @(posedge clk) begin
        ps_r[h] <= x2_r;
        pc_r[h] <= x2_r;
      end
    end else begin : g_rest
      logic [60:0] ms;
      logic [60:0] mc;
      always_comb begin
        ms = 61'(x2_r) * 61'(s_r[h]);
        mc = 61'(x2_r) * 61'(c_r[h]);
      end
      always_ff @(posedge clk) begin
        ps_r[h] <= ms[59:30];
        pc_r[h] <= mc[59:30];
      end
    end
    always_comb begin
      dvs = 62'(ps_r[h]) * 62'(SIN_RECIP[h]);
      dvc = 62'(pc_r[h]) * 62'(COS_RECIP[h]);
    end
    always_ff @(posedge clk) begin
      s_r[h+1] <= Q30_ONE - 31'(dvs >> SIN_SHIFT[h]);
      c_r[h+1] <= Q30_ONE - 31'(dvc >> COS_SHIFT[h]);
    end
  end

  logic [60:0] fm;
  always_comb fm = 61'(x1_r) * 61'(s_r[4]);

  always_ff @(posedge clk) begin
    sf_r <= fm[60:30];
    cf_r <= c_r[4];
  end

  logic [30:0] s_sum;
  logic [30:0] c_sum;
  trig_val_t   sm;
  trig_val_t   cm;
  trig_val_t   fs;
  trig_val_t   fc;
  trig_t       trig_nxt;

  always_comb begin
    s_sum = sf_r + TRIG_RND;
    c_sum = cf_r + TRIG_RND;
    sm = trig_val_t'({1'b0, s_sum[30:30-TRIG_F]});
    cm = trig_val_t'({1'b0, c_sum[30:30-TRIG_F]});
    fs = sw0_r ? cm : sm;
    fc = sw0_r ? sm : cm;
    case (q0_r)
      QUAD_0:  begin trig_nxt.sin_v = fs;  trig_nxt.cos_v = fc;  end
      QUAD_1:  begin trig_nxt.sin_v = fc;  trig_nxt.cos_v = -fs; end
      QUAD_2:  begin trig_nxt.sin_v = -fs; trig_nxt.cos_v = -fc; end
      QUAD_3:  begin trig_nxt.sin_v = -fc; trig_nxt.cos_v = fs;  end
      default: begin trig_nxt.sin_v = fs;  trig_nxt.cos_v = fc;  end
    endcase
  end

  always_ff @(posedge clk) begin
    trig_r <= trig_nxt;
  end

  assign trig = trig_r;

endmodule

// ----- rtl/rotate_point_3d_xyz.sv -----
// Top level: Euler X-Y-Z rotation of a 3D fixed-point point stream.
// The datapath has 19 register stages from the input to out_valid.
// Throughput: one transaction per cycle; loaded stages hold under back-pressure.
// Sine/cosine come from a 13-stage pipeline per axis that trails each angle reg.
// Reset (rst_n low, synchronous) clears all stage valids and the angle regs
// to zero; a transaction may be accepted on the first cycle after release.
`timescale 1ns / 1ps
`include "rotate_point_3d_xyz_defines.svh"
module rotate_point_3d_xyz
  import rp3_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  coord_t             in_x,
  input  coord_t             in_y,
  input  coord_t             in_z,
  output logic               out_valid,
  input  logic               out_ready,
  output coord_t             out_x,
  output coord_t             out_y,
  output coord_t             out_z,
  output logic               out_saturated,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [ANGLE_W-1:0] cfg_wdata
);

  // stage map: delay taps wait for the trig pipeline, then mult/sum per axis
  localparam int ST_XM = TRIG_LAT;
  localparam int ST_XS = ST_XM + 1;
  localparam int ST_YM = ST_XS + 1;
  localparam int ST_YS = ST_YM + 1;
  localparam int ST_ZM = ST_YS + 1;
  localparam int ST_ZS = ST_ZM + 1;
  localparam int N_ST  = ST_ZS + 1;

  // ---------------- configuration ----------------
  logic [ANGLE_W-1:0] ang_x_r, ang_y_r, ang_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_x_r <= '0;
      ang_y_r <= '0;
      ang_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ANGLE_X: ang_x_r <= cfg_wdata;
        REG_ANGLE_Y: ang_y_r <= cfg_wdata;
        REG_ANGLE_Z: ang_z_r <= cfg_wdata;
        default:     ;  // unmapped index, write dropped
      endcase
    end
  end

  // per-axis sine/cosine, settled once an angle write has run through the trig pipeline
  trig_t trig_x, trig_y, trig_z;

  rp3_trig u_trig_x (.clk(clk), .angle(ang_x_r), .trig(trig_x));
  rp3_trig u_trig_y (.clk(clk), .angle(ang_y_r), .trig(trig_y));
  rp3_trig u_trig_z (.clk(clk), .angle(ang_z_r), .trig(trig_z));

  // ---------------- flow control ----------------
  // A stage loads when empty or when the stage after it moves on.
  logic [N_ST-1:0] v_r;
  logic [N_ST-1:0] en;

  always_comb begin
    en[N_ST-1] = !v_r[N_ST-1] || out_ready;
    for (int i = N_ST - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_ready = rst_n && en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int i = 1; i < N_ST; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // ---------------- delay taps ----------------
  // The item passes as many tap registers as the trig pipeline has, so at the
  // X multiply it sees sine/cosine of the angle that stood when it entered.
  coord_t dx_r [TRIG_LAT];
  coord_t dy_r [TRIG_LAT];
  coord_t dz_r [TRIG_LAT];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx_r[0] <= in_x;
      dy_r[0] <= in_y;
      dz_r[0] <= in_z;
    end
    for (int i = 1; i < TRIG_LAT; i++) begin
      if (en[i]) begin
        dx_r[i] <= dx_r[i-1];
        dy_r[i] <= dy_r[i-1];
        dz_r[i] <= dz_r[i-1];
      end
    end
  end

  // ---------------- rotation about X ----------------
  prod_t  xm_yc_r, xm_zs_r, xm_ys_r, xm_zc_r;
  coord_t xm_x_r;

  always_ff @(posedge clk) begin
    if (en[ST_XM]) begin
      xm_yc_r <= mul_ct(dy_r[TRIG_LAT-1], trig_x.cos_v);
      xm_zs_r <= mul_ct(dz_r[TRIG_LAT-1], trig_x.sin_v);
      xm_ys_r <= mul_ct(dy_r[TRIG_LAT-1], trig_x.sin_v);
      xm_zc_r <= mul_ct(dz_r[TRIG_LAT-1], trig_x.cos_v);
      xm_x_r  <= dx_r[TRIG_LAT-1];
    end
  end

  rc_t    xs_y, xs_z;
  coord_t xs_x_r, xs_y_r, xs_z_r;
  logic   xs_sat_r;

  always_comb begin
    xs_y = rnd_clip(sum_t'(xm_yc_r) - sum_t'(xm_zs_r));
    xs_z = rnd_clip(sum_t'(xm_ys_r) + sum_t'(xm_zc_r));
  end

  always_ff @(posedge clk) begin
    if (en[ST_XS]) begin
      xs_x_r   <= xm_x_r;
      xs_y_r   <= xs_y.val;
      xs_z_r   <= xs_z.val;
      xs_sat_r <= xs_y.sat | xs_z.sat;
    end
  end

  // ---------------- rotation about Y ----------------
  prod_t  ym_xc_r, ym_zs_r, ym_xs_r, ym_zc_r;
  coord_t ym_y_r;
  logic   ym_sat_r;

  always_ff @(posedge clk) begin
    if (en[ST_YM]) begin
      ym_xc_r  <= mul_ct(xs_x_r, trig_y.cos_v);
      ym_zs_r  <= mul_ct(xs_z_r, trig_y.sin_v);
      ym_xs_r  <= mul_ct(xs_x_r, trig_y.sin_v);
      ym_zc_r  <= mul_ct(xs_z_r, trig_y.cos_v);
      ym_y_r   <= xs_y_r;
      ym_sat_r <= xs_sat_r;
    end
  end

  rc_t    ys_x, ys_z;
  coord_t ys_x_r, ys_y_r, ys_z_r;
  logic   ys_sat_r;

  always_comb begin
    ys_x = rnd_clip(sum_t'(ym_xc_r) + sum_t'(ym_zs_r));
    ys_z = rnd_clip(sum_t'(ym_zc_r) - sum_t'(ym_xs_r));
  end

  always_ff @(posedge clk) begin
    if (en[ST_YS]) begin
      ys_x_r   <= ys_x.val;
      ys_y_r   <= ym_y_r;
      ys_z_r   <= ys_z.val;
      ys_sat_r <= ym_sat_r | ys_x.sat | ys_z.sat;
    end
  end

  // ---------------- rotation about Z ----------------
  prod_t  zm_xc_r, zm_ys_r, zm_xs_r, zm_yc_r;
  coord_t zm_z_r;
  logic   zm_sat_r;

  always_ff @(posedge clk) begin
    if (en[ST_ZM]) begin
      zm_xc_r  <= mul_ct(ys_x_r, trig_z.cos_v);
      zm_ys_r  <= mul_ct(ys_y_r, trig_z.sin_v);
      zm_xs_r  <= mul_ct(ys_x_r, trig_z.sin_v);
      zm_yc_r  <= mul_ct(ys_y_r, trig_z.cos_v);
      zm_z_r   <= ys_z_r;
      zm_sat_r <= ys_sat_r;
    end
  end

  rc_t    zs_x, zs_y;
  coord_t zs_x_r, zs_y_r, zs_z_r;
  logic   zs_sat_r;

  always_comb begin
    zs_x = rnd_clip(sum_t'(zm_xc_r) - sum_t'(zm_ys_r));
    zs_y = rnd_clip(sum_t'(zm_xs_r) + sum_t'(zm_yc_r));
  end

  // last stage doubles as the output register
  always_ff @(posedge clk) begin
    if (en[ST_ZS]) begin
      zs_x_r   <= zs_x.val;
      zs_y_r   <= zs_y.val;
      zs_z_r   <= zm_z_r;
      zs_sat_r <= zm_sat_r | zs_x.sat | zs_y.sat;
    end
  end

  assign out_valid     = v_r[N_ST-1];
  assign out_x         = zs_x_r;
  assign out_y         = zs_y_r;
  assign out_z         = zs_z_r;
  assign out_saturated = zs_sat_r;

  // ---------------- checks ----------------
  `RP3_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid, "output valid right after reset")
  `RP3_ASSERT(a_drain_ready, !out_valid |-> in_ready, "input stalled with empty output stage")
  `RP3_ASSERT(a_fill_out, (v_r[N_ST-2] && !out_valid) |=> out_valid, "transaction lost before output")

endmodule
